// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ----- rtl/rlcpe_pkg.sv -----
`default_nettype none

package rlcpe_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Operation codes carried through the queue.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_DUTY  = 2'd3;

  // Register reset values.
  localparam logic [7:0] ONE_DUTY_RST  = 8'd64;
  localparam logic [7:0] ZERO_DUTY_RST = 8'd32;
  localparam logic [7:0] LATCH_RST     = 8'd40;
  localparam logic [7:0] END_DUTY_RST  = 8'd100;

  localparam int BITS_PER_LED = 24;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] led_num;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] one_bit_duty;
    logic [7:0] zero_bit_duty;
    logic [7:0] latch_slots;
    logic [7:0] end_duty;
  } cfg_t;

  // One classified operation, color already corrected and in GRB order.
  typedef struct packed {
    logic [1:0]  code;
    logic [7:0]  led_num;
    logic [23:0] color;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam logic [7:0] GAMMA [256] = '{
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
    8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
    8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
    8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,
    8'd16,8'd16,
    8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,
    8'd24,8'd25,
    8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,
    8'd35,8'd36,
    8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,
    8'd50,8'd50,
    8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,
    8'd67,8'd68,
    8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,
    8'd87,8'd89,
    8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,8'd102,8'd104,8'd105,8'd107,8'd109,
    8'd110,8'd112,8'd114,
    8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,8'd129,8'd131,8'd133,8'd135,
    8'd137,8'd138,8'd140,8'd142,
    8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,8'd160,8'd162,8'd164,8'd167,
    8'd169,8'd171,8'd173,8'd175,
    8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,8'd196,8'd198,8'd200,8'd203,
    8'd205,8'd208,8'd210,8'd213,
    8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,8'd236,8'd239,8'd241,8'd244,
    8'd247,8'd249,8'd252,8'd255
  };

  function automatic logic [7:0] gamma(input logic [7:0] x);
    return GAMMA[x];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rlcpe_front.sv -----
`default_nettype none

module rlcpe_front #(
  parameter int LED_COUNT = 8
) (
  input  wire logic           start,
  input  wire rlcpe_pkg::cmd_t cmd,
  input  wire logic           full,
  output logic                busy,
  output logic                push,
  output rlcpe_pkg::op_t      op
);
  import rlcpe_pkg::*;

  logic accept;
  logic idx_ok;

  // The queue status is registered, so busy never depends on start.
  assign busy   = full;
  assign accept = start && !busy;
  assign idx_ok = {1'b0, cmd.led_num} < 9'(LED_COUNT);

  // Classify the command; an out-of-range color write is dropped here.
  always_comb begin
    op.led_num = cmd.led_num;
    op.color   = {gamma(cmd.green), gamma(cmd.red), gamma(cmd.blue)};
    op.code    = OP_TICK;
    push       = 1'b0;
    unique case (cmd.mode)
      MODE_WRITE: begin
        op.code = OP_WRITE;
        push    = accept && idx_ok;
      end
      MODE_CLEAR: begin
        op.code = OP_CLEAR;
        push    = accept;
      end
      MODE_START: begin
        op.code = OP_START;
        push    = accept;
      end
      MODE_TICK: begin
        op.code = OP_TICK;
        push    = accept;
      end
      default: begin
        op.code = OP_TICK;
        push    = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rlcpe_queue.sv -----
`default_nettype none

module rlcpe_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rlcpe_pkg::op_t  push_op,
  input  wire logic            pop,
  output rlcpe_pkg::op_t       pop_op,
  output rlcpe_pkg::qstat_t    status
);
  import rlcpe_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  op_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = count == (AW+1)'(DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_op       = slots[rd_ptr];

  // Storage for queued beats.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rlcpe_back.sv -----
`default_nettype none

module rlcpe_back #(
  parameter int LED_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rlcpe_pkg::cfg_t   cfg,
  input  wire rlcpe_pkg::qstat_t qstat,
  input  wire rlcpe_pkg::op_t    op,
  output logic                   pop,
  output logic                   strobe,
  output rlcpe_pkg::result_t     result
);
  import rlcpe_pkg::*;

  localparam int COLOR_SLOTS = LED_COUNT * BITS_PER_LED;
  localparam int POS_W       = $clog2(255 + COLOR_SLOTS + 2);
  localparam int KW          = $clog2(COLOR_SLOTS);
  localparam int XW          = KW - 3;
  localparam int PW          = XW + 10;
  localparam int QW          = PW - 11;
  localparam int LED_AW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [PW-1:0] RECIP3 = PW'(683);

  localparam logic [1:0] KIND_LATCH = 2'd0;
  localparam logic [1:0] KIND_COLOR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Frame state.
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             active;
  logic             active_next;

  // Stage A: executed operation.
  logic              a_tick;
  logic              a_wr;
  logic              a_clr;
  logic [1:0]        a_kind;
  logic [KW-1:0]     a_k;
  logic [LED_AW-1:0] a_idx;
  logic [23:0]       a_color;

  logic             op_valid;
  logic [POS_W-1:0] latch_ext;
  logic [POS_W-1:0] k_full;
  logic             tick_next;
  logic [1:0]       kind_next;

  // Stage B: store read.
  logic [23:0]       mem [LED_COUNT];
  logic [LED_COUNT-1:0] led_valid;
  logic              b_tick;
  logic [1:0]        b_kind;
  logic [4:0]        b_bit;
  logic [23:0]       b_word;
  logic              b_wvalid;

  logic [XW-1:0]     x;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     q;
  logic [1:0]        rem3;
  logic [4:0]        rem;
  logic [LED_AW-1:0] rd_addr;
  logic              color_bit;

  // The back end never stalls, so it drains one beat per cycle.
  assign pop      = !qstat.empty;
  assign op_valid = !qstat.empty;

  assign latch_ext = POS_W'(cfg.latch_slots);
  assign k_full    = pos - latch_ext;

  // Slot classification against the live register values.
  always_comb begin
    pos_next    = pos;
    active_next = active;
    tick_next   = 1'b0;
    kind_next   = KIND_LATCH;
    if (op_valid) begin
      unique case (op.code)
        OP_START: begin
          active_next = 1'b1;
          pos_next    = '0;
        end
        OP_TICK: begin
          if (active) begin
            tick_next = 1'b1;
            if (pos < latch_ext) begin
              kind_next = KIND_LATCH;
              pos_next  = pos + 1'b1;
            end else if (k_full < POS_W'(COLOR_SLOTS)) begin
              kind_next = KIND_COLOR;
              pos_next  = pos + 1'b1;
            end else begin
              kind_next   = KIND_END;
              pos_next    = '0;
              active_next = 1'b0;
            end
          end
        end
        default: begin
          pos_next = pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      active <= 1'b0;
      a_tick <= 1'b0;
      a_wr   <= 1'b0;
      a_clr  <= 1'b0;
    end else begin
      pos    <= pos_next;
      active <= active_next;
      a_tick <= tick_next;
      a_wr   <= op_valid && (op.code == OP_WRITE);
      a_clr  <= op_valid && (op.code == OP_CLEAR);
    end
  end

  always_ff @(posedge clk) begin
    a_kind  <= kind_next;
    a_k     <= KW'(k_full);
    a_idx   <= LED_AW'(op.led_num);
    a_color <= op.color;
  end

  // LED number and bit position: k / 24 is (k >> 3) / 3 by reciprocal.
  assign x       = a_k[KW-1:3];
  assign prod    = PW'(x) * RECIP3;
  assign q       = prod[PW-1:11];
  assign rem3    = 2'(x - XW'(q) - XW'({q, 1'b0}));
  assign rem     = {rem3, a_k[2:0]};
  assign rd_addr = LED_AW'(q);

  // Color store; a write lands in the same stage as a read, so order holds.
  always_ff @(posedge clk) begin
    if (a_wr) begin
      mem[a_idx] <= a_color;
    end
    b_word <= mem[rd_addr];
  end

  // Per-LED valid bits stand for the clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= '0;
    end else if (a_clr) begin
      led_valid <= '0;
    end else if (a_wr) begin
      led_valid[a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tick <= 1'b0;
    end else begin
      b_tick <= a_tick;
    end
  end

  always_ff @(posedge clk) begin
    b_kind   <= a_kind;
    b_bit    <= 5'(BITS_PER_LED - 1) - rem;
    b_wvalid <= led_valid[rd_addr];
  end

  assign color_bit = b_wvalid && b_word[b_bit];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe      <= 1'b0;
      result.last <= 1'b0;
    end else begin
      strobe      <= b_tick;
      result.last <= b_tick && (b_kind == KIND_END);
    end
  end

  always_ff @(posedge clk) begin
    case (b_kind)
      KIND_COLOR: result.duty <= color_bit ? cfg.one_bit_duty : cfg.zero_bit_duty;
      KIND_END:   result.duty <= cfg.end_duty;
      default:    result.duty <= '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rgb_led_chain_pulse_encoder.sv -----
// Serial RGB LED chain pulse encoder.
//
// Commands arrive on cmd and are taken at a rising edge with start high and
// busy low: color write (gamma-corrected, stored in GRB order), clear all,
// start frame, and tick. Each tick inside a frame yields one beat on result,
// marked by strobe for one cycle: latch_slots zero-duty slots, then 24 bits
// per LED (LED 0 first, MSB first) as one or zero duty, then the end slot
// with last set. Ticks outside a frame give no beat.
// A tick passes through the command queue, stage A, stage B and the result
// register before its beat shows strobe. Throughput: one command per cycle;
// the slot sequencer drains the four-entry command queue every cycle, so
// busy stays low in practice and rises only if the queue is full.
// Registers are written through cfg_we/cfg_index/cfg_data with no wait; the
// user must write them only while the block is idle, which it does not enforce.
// Reset clears every LED to zero, ends any frame, empties the queue and
// returns the registers to 64, 32, 40 and 100. The receiver cannot stall.
`default_nettype none

module rgb_led_chain_pulse_encoder #(
  parameter int LED_COUNT = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire rlcpe_pkg::cmd_t                     cmd,
  output logic                                     strobe,
  output rlcpe_pkg::result_t                       result,
  input  wire logic                                cfg_we,
  input  wire logic [rlcpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                          cfg_data
);
  import rlcpe_pkg::*;

  `include "assert_macros.svh"

  cfg_t   cfg;
  qstat_t qstat;
  op_t    push_op;
  op_t    pop_op;
  logic   push;
  logic   pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_bit_duty  <= ONE_DUTY_RST;
      cfg.zero_bit_duty <= ZERO_DUTY_RST;
      cfg.latch_slots   <= LATCH_RST;
      cfg.end_duty      <= END_DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_DUTY:  cfg.one_bit_duty  <= cfg_data;
        REG_ZERO_DUTY: cfg.zero_bit_duty <= cfg_data;
        REG_LATCH:     cfg.latch_slots   <= cfg_data;
        REG_END_DUTY:  cfg.end_duty      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rlcpe_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .start(start),
    .cmd  (cmd),
    .full (qstat.full),
    .busy (busy),
    .push (push),
    .op   (push_op)
  );

  rlcpe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .pop_op (pop_op),
    .status (qstat)
  );

  rlcpe_back #(
    .LED_COUNT(LED_COUNT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .qstat (qstat),
    .op    (pop_op),
    .pop   (pop),
    .strobe(strobe),
    .result(result)
  );

  // The front end never pushes into a full queue.
  `ASSERT_IMPLY(a_no_push_full, clk, rst, push, !qstat.full)
  // A full queue cannot also read as empty.
  `ASSERT_IMPLY(a_full_not_empty, clk, rst, qstat.full, !qstat.empty)
  // The end-of-frame flag only rides on a strobed beat.
  `ASSERT_IMPLY(a_last_strobed, clk, rst, result.last, strobe)
  // An end slot closes the frame, so two end slots never come back to back.
  `ASSERT_NEXT(a_single_end, clk, rst, strobe && result.last, !(strobe && result.last))

endmodule

`default_nettype wire
